// ===== hdl/bal_pkg.sv =====
// Shared types and constants for the bounded array list.
// Used by bal_cell and bounded_array_list_top; depends on nothing.
`default_nettype none

package bal_pkg;

  localparam int DEPTH  = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 6;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_UPDATE = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_READ   = 3'd5
  } req_t;

  // Decoded request broadcast to every cell; each flag is already
  // qualified with the accept handshake and the range checks.
  typedef struct packed {
    logic  do_append;
    logic  do_update;
    logic  do_insert;
    logic  do_delete;
    idx_t  idx;
    idx_t  tail;   // slot an append writes
    data_t value;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/bounded_array_list_top.sv =====
// Top level of the bounded array list: request decode, count and capacity
// registers, the row of bal_cell slots and the result register. Uses bal_pkg.
`default_nettype none

// Ordered list of up to 32 signed 32-bit entries held in a row of register
// cells. Each request (append, update, insert, delete, clear, read) is
// applied at once: the cells shift up or down together, so a request
// can be taken every cycle and its result appears in the output register
// on the next. The input is held off only while a result waits unread.
// Capacity is written through cfg_* and must only change while idle; the
// count is cut to the new capacity. A capacity of 0 acts as 1 and one
// above 32 as 32. Entry contents need no reset.
module bounded_array_list_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] req_type, [7:3] index, [39:8] value
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] read_value, [32] applied, [38:33] entry_count,
  // [39] is_empty_flag, [40] is_full_flag, [47:41] zero
  output logic [47:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data
);

  localparam int DEPTH = bal_pkg::DEPTH;

  logic                   in_fire;
  logic [2:0]             req_raw;
  bal_pkg::idx_t          req_idx;
  bal_pkg::data_t         req_val;
  logic                   hit;
  bal_pkg::cell_cmd_t     cmd;
  bal_pkg::data_t         entry   [DEPTH];
  bal_pkg::cnt_t          cap_eff;
  bal_pkg::cnt_t          cap_r;
  bal_pkg::cnt_t          cap_nxt;
  bal_pkg::cnt_t          occ_r;
  bal_pkg::cnt_t          occ_nxt;
  logic                   applied;
  bal_pkg::data_t         rd_val;
  logic                   out_valid_r;
  logic [47:0]            out_data_r;
  logic [47:0]            out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign req_raw = in_tdata[2:0];
  assign req_idx = in_tdata[7:3];
  assign req_val = in_tdata[39:8];
  assign hit     = bal_pkg::cnt_t'(req_idx) < occ_r;

  // clamp the written capacity into 1..DEPTH
  always_comb begin
    if (cfg_data == '0) begin
      cap_nxt = bal_pkg::cnt_t'(1);
    end else if (bal_pkg::cnt_t'(cfg_data) > bal_pkg::cnt_t'(DEPTH)) begin
      cap_nxt = bal_pkg::cnt_t'(DEPTH);
    end else begin
      cap_nxt = bal_pkg::cnt_t'(cfg_data);
    end
  end
  assign cap_eff = cap_r;

  always_comb begin
    cmd.do_append = in_fire && (req_raw == bal_pkg::REQ_APPEND) && (occ_r < cap_eff);
    cmd.do_update = in_fire && (req_raw == bal_pkg::REQ_UPDATE) && hit;
    cmd.do_insert = in_fire && (req_raw == bal_pkg::REQ_INSERT) && hit;
    cmd.do_delete = in_fire && (req_raw == bal_pkg::REQ_DELETE) && hit;
    cmd.idx       = req_idx;
    cmd.tail      = occ_r[bal_pkg::IDX_W-1:0];
    cmd.value     = req_val;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bal_pkg::data_t lower;
    bal_pkg::data_t upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign upper = entry[g];
    end else begin : g_mid_hi
      assign upper = entry[g+1];
    end
    bal_cell u_cell (
      .clk        (clk),
      .pos        (bal_pkg::idx_t'(g)),
      .cmd        (cmd),
      .lower_data (lower),
      .upper_data (upper),
      .data       (entry[g])
    );
  end

  always_comb begin
    occ_nxt = occ_r;
    applied = 1'b0;
    rd_val  = '0;
    if (in_fire) begin
      unique case (req_raw)
        bal_pkg::REQ_APPEND: begin
          if (cmd.do_append) begin
            occ_nxt = occ_r + bal_pkg::cnt_t'(1);
            applied = 1'b1;
          end
        end
        bal_pkg::REQ_UPDATE: applied = hit;
        bal_pkg::REQ_INSERT: begin
          if (hit) begin
            applied = 1'b1;
            if (occ_r < cap_eff) begin
              occ_nxt = occ_r + bal_pkg::cnt_t'(1);
            end
          end
        end
        bal_pkg::REQ_DELETE: begin
          if (hit) begin
            applied = 1'b1;
            occ_nxt = occ_r - bal_pkg::cnt_t'(1);
          end
        end
        bal_pkg::REQ_CLEAR: begin
          applied = 1'b1;
          occ_nxt = '0;
        end
        bal_pkg::REQ_READ: begin
          if (hit) begin
            applied = 1'b1;
            rd_val  = entry[req_idx];
          end
        end
        default: applied = 1'b0;
      endcase
    end else if (cfg_valid && (occ_r > cap_nxt)) begin
      occ_nxt = cap_nxt;
    end
  end

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[31:0]  = rd_val;
    out_data_nxt[32]    = applied;
    out_data_nxt[38:33] = occ_nxt;
    out_data_nxt[39]    = (occ_nxt == '0);
    out_data_nxt[40]    = (occ_nxt == cap_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= bal_pkg::cnt_t'(DEPTH);
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cap_nxt;
      end
      occ_r <= occ_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/bal_cell.sv =====
// One slot of the list: holds an entry and loads from the request value
// or from its lower or upper neighbor. Depends on bal_pkg.
`default_nettype none

module bal_cell (
  input  wire logic              clk,
  input  wire bal_pkg::idx_t     pos,
  input  wire bal_pkg::cell_cmd_t cmd,
  input  wire bal_pkg::data_t    lower_data,
  input  wire bal_pkg::data_t    upper_data,
  output bal_pkg::data_t         data
);

  bal_pkg::data_t data_r;
  bal_pkg::data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.do_append && (pos == cmd.tail)) begin
      data_nxt = cmd.value;
    end else if (cmd.do_update && (pos == cmd.idx)) begin
      data_nxt = cmd.value;
    end else if (cmd.do_insert) begin
      if (pos == cmd.idx) begin
        data_nxt = cmd.value;
      end else if (pos > cmd.idx) begin
        data_nxt = lower_data;
      end
    end else if (cmd.do_delete && (pos >= cmd.idx)) begin
      data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== test/bal_list_checker.sv =====
`timescale 1ns / 100ps
// Result checker for bounded_array_list_top: keeps a shadow list fed from the
// request and capacity channels and compares every result transaction.
// Depends on bal_pkg for widths and request codes.
module bal_list_checker
  import bal_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output cnt_t        list_level
);

  localparam int SHOW_LIMIT = 40;

  // Member order matches out_tdata[40:0], highest bit first.
  typedef struct packed {
    logic       full;
    logic       empty;
    logic [5:0] entry_count;
    logic       applied;
    data_t      read_value;
  } list_result_t;

  data_t            shadow_mem [DEPTH];
  cnt_t             shadow_count;
  logic [CAP_W-1:0] shadow_cap;
  list_result_t     expected_q [$];
  list_result_t     exp_r;
  list_result_t     got_r;
  logic [6:0]       got_pad;
  int               shown;
  int               k;

  function automatic cnt_t usable_slots(input logic [CAP_W-1:0] c);
    if (c == '0) return cnt_t'(1);
    if (c > DEPTH) return cnt_t'(DEPTH);
    return cnt_t'(c);
  endfunction

  task automatic apply_request(input logic [2:0] req, input idx_t idx, input data_t val,
                               output list_result_t r);
    cnt_t lim;
    cnt_t grown;
    logic hit;
    int   i;
    lim = usable_slots(shadow_cap);
    hit = (cnt_t'(idx) < shadow_count);
    r = '0;
    case (req)
      REQ_APPEND: begin
        if (shadow_count < lim) begin
          shadow_mem[shadow_count] = val;
          shadow_count = shadow_count + 1'b1;
          r.applied = 1'b1;
        end
      end
      REQ_UPDATE: begin
        if (hit) begin
          shadow_mem[idx] = val;
          r.applied = 1'b1;
        end
      end
      REQ_INSERT: begin
        if (hit) begin
          // a full list keeps its count; the last entry falls off the end
          grown = (shadow_count + 1'b1 > lim) ? lim : shadow_count + 1'b1;
          for (i = int'(grown) - 1; i > int'(idx); i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[idx] = val;
          shadow_count = grown;
          r.applied = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          for (i = int'(idx); i + 1 < int'(shadow_count); i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_count = shadow_count - 1'b1;
          r.applied = 1'b1;
        end
      end
      REQ_CLEAR: begin
        shadow_count = '0;
        r.applied = 1'b1;
      end
      REQ_READ: begin
        if (hit) begin
          r.read_value = shadow_mem[idx];
          r.applied = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_count;
    r.empty = (shadow_count == '0);
    r.full = (shadow_count == lim);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (k = 0; k < DEPTH; k++) shadow_mem[k] = '0;
      shadow_count = '0;
      shadow_cap = 6'd32;
      expected_q.delete();
      fail_count = 0;
      checked = 0;
      shown = 0;
    end else begin
      // result first: it belongs to an earlier request than one taken this edge
      if (out_tvalid && out_tready) begin
        got_r = out_tdata[40:0];
        got_pad = out_tdata[47:41];
        if (expected_q.size() == 0) begin
          fail_count++;
          if (shown < SHOW_LIMIT)
            $display("%0t: result transaction with no request outstanding: %h", $time,
                     out_tdata);
          shown++;
        end else begin
          exp_r = expected_q.pop_front();
          checked++;
          if (got_r.read_value !== exp_r.read_value || got_r.applied !== exp_r.applied ||
              got_r.entry_count !== exp_r.entry_count || got_r.empty !== exp_r.empty ||
              got_r.full !== exp_r.full || got_pad !== '0) begin
            fail_count++;
            if (shown < SHOW_LIMIT)
              $display({"%0t: mismatch: expected value=%h applied=%b count=%0d empty=%b ",
                        "full=%b, actual value=%h applied=%b count=%0d empty=%b full=%b pad=%h"},
                       $time, exp_r.read_value, exp_r.applied, exp_r.entry_count, exp_r.empty,
                       exp_r.full, got_r.read_value, got_r.applied, got_r.entry_count,
                       got_r.empty, got_r.full, got_pad);
            else if (shown == SHOW_LIMIT)
              $display("%0t: further mismatches counted but not shown", $time);
            shown++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        shadow_cap = cfg_data;
        if (shadow_count > usable_slots(shadow_cap)) shadow_count = usable_slots(shadow_cap);
      end
      if (in_tvalid && in_tready) begin
        apply_request(in_tdata[2:0], in_tdata[7:3], in_tdata[39:8], exp_r);
        expected_q.push_back(exp_r);
      end
    end
    pending = expected_q.size();
    list_level = shadow_count;
  end

endmodule

// ===== test/tb_bounded_array_list_top.sv =====
`timescale 1ns / 100ps
// Testbench top for bounded_array_list_top: drives list requests and capacity
// writes, paces the result channel and gives the verdict from bal_list_checker.
module tb_bounded_array_list_top;
  import bal_pkg::*;

  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_LEN   = 120;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 1000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;

  int   fail_count;
  int   pending;
  int   checked;
  cnt_t list_level;
  int   sent = 0;
  int   cfg_writes = 0;
  bit   quiet = 1'b0;
  bit   long_hold = 1'b0;

  always #5 clk = ~clk;

  bounded_array_list_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  bal_list_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .list_level (list_level)
  );

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Regression FAIL");
    $finish;
  end

  // Result side pacing; a long hold lets the result register back up the input.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        long_hold <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the rising edge that takes the transaction.
  task automatic drive_req(input logic [2:0] req, input idx_t idx, input data_t val);
    in_tvalid <= 1'b1;
    in_tdata  <= {val, idx, req};
    sent++;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 9);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic put_req(input logic [2:0] req, input idx_t idx, input data_t val);
    sender_gap();
    @(negedge clk);
    drive_req(req, idx, val);
  endtask

  // Fields are picked after the falling edge, once the checker has seen the
  // previous transaction, so indexes can aim at occupied slots.
  task automatic put_random();
    logic [2:0] req;
    idx_t       idx;
    data_t      val;
    int         pick;
    sender_gap();
    @(negedge clk);
    pick = $urandom_range(0, 99);
    if (pick < 26)      req = REQ_APPEND;
    else if (pick < 40) req = REQ_UPDATE;
    else if (pick < 54) req = REQ_INSERT;
    else if (pick < 71) req = REQ_DELETE;
    else if (pick < 74) req = REQ_CLEAR;
    else if (pick < 95) req = REQ_READ;
    else                req = $urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B;
    if (list_level != 0 && $urandom_range(0, 7) != 0)
      idx = idx_t'($urandom_range(0, list_level - 1));
    else
      idx = idx_t'($urandom_range(0, DEPTH - 1));
    case ($urandom_range(0, 15))
      0:       val = data_t'(32'h8000_0000);
      1:       val = data_t'(32'h7fff_ffff);
      2:       val = '0;
      3:       val = '1;
      default: val = data_t'($urandom);
    endcase
    drive_req(req, idx, val);
  endtask

  // Capacity may only change with nothing in flight.
  task automatic write_capacity(input logic [5:0] cap);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    cfg_writes++;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int         ph;
    int         k;
    int         drain_wait;
    logic [5:0] cap;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // empty list: only clear takes effect; then appends, reads, updates, an insert, a delete and the spare codes
    put_req(REQ_CLEAR, 0, 0);
    put_req(REQ_READ, 0, 0);
    put_req(REQ_DELETE, 31, 0);
    put_req(REQ_APPEND, 0, 32'h8000_0000);
    put_req(REQ_APPEND, 31, 32'h7fff_ffff);
    put_req(REQ_APPEND, 0, 0);
    put_req(REQ_APPEND, 0, 32'hffff_ffff);
    put_req(REQ_READ, 0, 0);
    put_req(REQ_READ, 4, 0);
    put_req(REQ_UPDATE, 1, 32'h1234_5678);
    put_req(REQ_UPDATE, 4, 32'hdead_beef);
    put_req(REQ_INSERT, 0, 32'ha5a5_a5a5);
    put_req(REQ_DELETE, 2, 0);
    put_req(REQ_SPARE_A, 0, 32'hffff_ffff);
    put_req(REQ_SPARE_B, 31, 32'h5a5a_5a5a);
    // shrinking below the count drops the tail
    write_capacity(6'd2);
    put_req(REQ_APPEND, 0, 7);
    put_req(REQ_INSERT, 1, 32'h0f0f_0f0f);
    put_req(REQ_READ, 1, 0);
    // zero behaves as a single slot
    write_capacity(6'd0);
    put_req(REQ_INSERT, 0, 32'h8000_0001);
    put_req(REQ_READ, 0, 0);
    put_req(REQ_DELETE, 0, 0);
    put_req(REQ_APPEND, 0, 3);
    put_req(REQ_APPEND, 0, 4);
    // above the store depth clamps to the depth
    write_capacity(6'd63);
    put_req(REQ_READ, 0, 0);
    put_req(REQ_CLEAR, 0, 0);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       cap = 6'd32;
        1:       cap = 6'd1;
        2:       cap = 6'd5;
        3:       cap = 6'd0;
        4:       cap = 6'd63;
        5:       cap = 6'd31;
        6:       cap = 6'd33;
        default: cap = 6'($urandom_range(0, 63));
      endcase
      write_capacity(cap);
      if (ph == 2) long_hold <= 1'b1;
      if (ph >= NUM_PHASES - 2) quiet <= 1'b1;
      for (k = 0; k < PHASE_LEN; k++) put_random();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    drain_wait = 0;
    while (pending != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (4) @(negedge clk);

    $display("Covered %0d requests and %0d checked results over %0d capacity settings,",
             sent, checked, cfg_writes);
    $display("including clamped capacities, full-list inserts and a long result-side hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bal_pkg.sv
hdl/bal_cell.sv
hdl/bounded_array_list_top.sv
test/bal_list_checker.sv
test/tb_bounded_array_list_top.sv
